>>> hw/rtl/crc8fu_pkg.sv
// ----------------------------------------------------------------------------
// crc8fu_pkg
// Shared types, constants and the CRC-8 step function of the framed receiver.
// ----------------------------------------------------------------------------
package crc8fu_pkg;

    // Frame geometry
    localparam int MAX_FRAME   = 64;
    localparam int PAYLOAD_MAX = MAX_FRAME - 4;
    localparam int IDX_W       = 6;
    localparam int BANK_DEPTH  = 2 ** IDX_W;
    localparam int RAM_DEPTH   = 2 * BANK_DEPTH;
    localparam int RAM_AW      = IDX_W + 1;

    // Frame marker bytes and CRC polynomial
    localparam logic [7:0] HEAD1_BYTE = 8'hAA;
    localparam logic [7:0] HEAD2_BYTE = 8'h55;
    localparam logic [7:0] TAIL1_BYTE = 8'h0D;
    localparam logic [7:0] TAIL2_BYTE = 8'h0A;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_FRAME   = 2'd0,
        STAT_CRC_ERR = 2'd1,
        STAT_LEN_ERR = 2'd2
    } status_t;

    // Parser states
    typedef enum logic [2:0] {
        PS_HEAD1 = 3'd0,
        PS_HEAD2 = 3'd1,
        PS_LEN   = 3'd2,
        PS_CMD   = 3'd3,
        PS_DATA  = 3'd4,
        PS_CRC   = 3'd5,
        PS_TAIL1 = 3'd6,
        PS_TAIL2 = 3'd7
    } parse_state_t;

    // Drain engine states
    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_DRAIN = 1'b1
    } back_state_t;

    // One finished event handed from the parser to the drain engine
    typedef struct packed {
        status_t            status;
        logic [7:0]         command;
        logic [IDX_W-1:0]   length;
        logic               bank;
    } frame_entry_t;

    // Drain engine tells the parser a payload bank is read out
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_free_t;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_shift_byte(input logic [7:0] crc,
                                                   input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/crc8fu_ram.sv
// ----------------------------------------------------------------------------
// crc8fu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crc8fu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/crc8fu_front.sv
// ----------------------------------------------------------------------------
// crc8fu_front
// Byte parser: hunts for frames, runs the CRC, stores payload into a bank
// of the payload RAM and posts frame and error events to the queue.
// ----------------------------------------------------------------------------
module crc8fu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    byte_in,
    input  logic                          q_full,
    output logic                          push,
    output crc8fu_pkg::frame_entry_t      push_entry,
    input  crc8fu_pkg::bank_free_t        bank_free,
    output logic                          wr_en,
    output logic [crc8fu_pkg::RAM_AW-1:0] wr_addr,
    output logic [7:0]                    wr_data
);

    crc8fu_pkg::parse_state_t               state_reg, state_next, state_step;
    logic [crc8fu_pkg::IDX_W-1:0]           fill_reg, fill_next;
    logic [crc8fu_pkg::IDX_W-1:0]           len_reg, len_next;
    logic [7:0]                             cmd_reg, cmd_next;
    logic [7:0]                             crc_reg, crc_next;
    logic                                   wr_bank_reg, wr_bank_next;
    logic [1:0]                             busy_reg, busy_next;

    logic                                   accept;
    logic [7:0]                             crc_step;
    logic [crc8fu_pkg::IDX_W-1:0]           fill_inc;
    logic                                   len_ok;
    logic                                   frame_done;

    // handshake: stall when the queue is full or the fill bank still holds an undrained frame
    assign in_ready = !q_full &&
                      !(state_reg == crc8fu_pkg::PS_DATA && busy_reg[wr_bank_reg]);
    assign accept   = in_valid && in_ready;

    // datapath helpers
    assign crc_step = crc8fu_pkg::crc8_shift_byte(
                          (state_reg == crc8fu_pkg::PS_LEN) ? 8'h00 : crc_reg, byte_in);
    assign fill_inc = fill_reg + 1'b1;
    assign len_ok   = byte_in <= 8'(crc8fu_pkg::PAYLOAD_MAX);

    // next state
    always_comb
    begin
        state_step = state_reg;
        case (state_reg)
            crc8fu_pkg::PS_HEAD1:
                if (byte_in == crc8fu_pkg::HEAD1_BYTE)
                    state_step = crc8fu_pkg::PS_HEAD2;
            crc8fu_pkg::PS_HEAD2:
                state_step = (byte_in == crc8fu_pkg::HEAD2_BYTE) ?
                             crc8fu_pkg::PS_LEN : crc8fu_pkg::PS_HEAD1;
            crc8fu_pkg::PS_LEN:
                state_step = len_ok ? crc8fu_pkg::PS_CMD : crc8fu_pkg::PS_HEAD1;
            crc8fu_pkg::PS_CMD:
                state_step = (len_reg != '0) ? crc8fu_pkg::PS_DATA : crc8fu_pkg::PS_CRC;
            crc8fu_pkg::PS_DATA:
                state_step = (fill_inc >= len_reg) ? crc8fu_pkg::PS_CRC
                                                   : crc8fu_pkg::PS_DATA;
            crc8fu_pkg::PS_CRC:
                state_step = (byte_in == crc_reg) ? crc8fu_pkg::PS_TAIL1
                                                  : crc8fu_pkg::PS_HEAD1;
            crc8fu_pkg::PS_TAIL1:
                state_step = (byte_in == crc8fu_pkg::TAIL1_BYTE) ?
                             crc8fu_pkg::PS_TAIL2 : crc8fu_pkg::PS_HEAD1;
            crc8fu_pkg::PS_TAIL2:
                state_step = crc8fu_pkg::PS_HEAD1;
            default:
                state_step = crc8fu_pkg::PS_HEAD1;
        endcase
        state_next = accept ? state_step : state_reg;
    end

    // event posting and payload writes
    always_comb
    begin
        push               = 1'b0;
        push_entry.status  = crc8fu_pkg::STAT_FRAME;
        push_entry.command = cmd_reg;
        push_entry.length  = len_reg;
        push_entry.bank    = wr_bank_reg;
        frame_done         = 1'b0;
        wr_en              = 1'b0;
        case (state_reg)
            crc8fu_pkg::PS_LEN:
                if (!len_ok)
                begin
                    push               = accept;
                    push_entry.status  = crc8fu_pkg::STAT_LEN_ERR;
                    push_entry.command = '0;
                    push_entry.length  = '0;
                end
            crc8fu_pkg::PS_DATA:
                wr_en = accept;
            crc8fu_pkg::PS_CRC:
                if (byte_in != crc_reg)
                begin
                    push              = accept;
                    push_entry.status = crc8fu_pkg::STAT_CRC_ERR;
                end
            crc8fu_pkg::PS_TAIL2:
                if (byte_in == crc8fu_pkg::TAIL2_BYTE)
                begin
                    push       = accept;
                    frame_done = accept;
                end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign wr_addr = {wr_bank_reg, fill_reg};
    assign wr_data = byte_in;

    // frame registers
    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        cmd_next  = cmd_reg;
        crc_next  = crc_reg;
        if (accept)
        begin
            case (state_reg)
                crc8fu_pkg::PS_LEN:
                begin
                    len_next  = byte_in[crc8fu_pkg::IDX_W-1:0];
                    crc_next  = crc_step;
                    fill_next = '0;
                end
                crc8fu_pkg::PS_CMD:
                begin
                    cmd_next = byte_in;
                    crc_next = crc_step;
                end
                crc8fu_pkg::PS_DATA:
                begin
                    fill_next = fill_inc;
                    crc_next  = crc_step;
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    // bank ownership: a bank with payload is busy until drained
    always_comb
    begin
        busy_next    = busy_reg;
        wr_bank_next = wr_bank_reg;
        if (bank_free.valid)
            busy_next[bank_free.bank] = 1'b0;
        if (frame_done && len_reg != '0)
        begin
            busy_next[wr_bank_reg] = 1'b1;
            wr_bank_next           = !wr_bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crc8fu_pkg::PS_HEAD1;
            fill_reg    <= '0;
            len_reg     <= '0;
            cmd_reg     <= '0;
            crc_reg     <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            cmd_reg     <= cmd_next;
            crc_reg     <= crc_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

>>> hw/rtl/crc8fu_queue.sv
// ----------------------------------------------------------------------------
// crc8fu_queue
// Two-entry event queue between the parser and the drain engine.
// ----------------------------------------------------------------------------
module crc8fu_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  crc8fu_pkg::frame_entry_t push_entry,
    output logic                     full,
    input  logic                     pop,
    output logic                     q_valid,
    output crc8fu_pkg::frame_entry_t q_entry
);

    crc8fu_pkg::frame_entry_t entry_reg [2];
    logic                     wr_ptr_reg, wr_ptr_next;
    logic                     rd_ptr_reg, rd_ptr_next;
    logic [1:0]               count_reg, count_next;
    logic                     do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_entry = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/crc8fu_back.sv
// ----------------------------------------------------------------------------
// crc8fu_back
// Drain engine: turns queued events into result beats, reading the payload
// bank one byte per beat through the registered RAM port.
// ----------------------------------------------------------------------------
module crc8fu_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  crc8fu_pkg::frame_entry_t      q_entry,
    output logic                          pop,
    output logic                          rd_en,
    output logic [crc8fu_pkg::RAM_AW-1:0] rd_addr,
    input  logic [7:0]                    rd_data,
    output crc8fu_pkg::bank_free_t        bank_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [7:0]                    command,
    output logic [5:0]                    payload_length,
    output logic [7:0]                    payload_byte,
    output logic [5:0]                    byte_index,
    output logic                          last
);

    crc8fu_pkg::back_state_t          state_reg, state_next;
    logic [7:0]                       cmd_reg;
    logic [crc8fu_pkg::IDX_W-1:0]     len_reg;
    logic                             bank_reg;
    logic [crc8fu_pkg::IDX_W-1:0]     idx_reg;
    logic [crc8fu_pkg::IDX_W-1:0]     rd_idx_reg;
    logic                             rd_last_reg;
    logic                             rd_pend_reg;

    logic                             out_valid_reg;
    crc8fu_pkg::status_t              status_reg;
    logic [7:0]                       command_reg;
    logic [5:0]                       length_reg;
    logic [7:0]                       pbyte_reg;
    logic [5:0]                       index_reg;
    logic                             last_reg;

    logic                             out_free;
    logic                             can_take;
    logic                             is_drain;
    logic                             take_single;
    logic                             start;
    logic                             issue;
    logic                             final_read;

    assign out_free   = !out_valid_reg || out_ready;
    assign can_take   = q_valid && out_free && !rd_pend_reg;
    assign is_drain   = q_entry.status == crc8fu_pkg::STAT_FRAME && q_entry.length != '0;
    assign final_read = idx_reg == len_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crc8fu_pkg::BK_IDLE:
                if (can_take && is_drain)
                    state_next = crc8fu_pkg::BK_DRAIN;
            crc8fu_pkg::BK_DRAIN:
                if (!rd_pend_reg && out_free && final_read)
                    state_next = crc8fu_pkg::BK_IDLE;
            default:
                state_next = crc8fu_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        take_single = 1'b0;
        start       = 1'b0;
        issue       = 1'b0;
        case (state_reg)
            crc8fu_pkg::BK_IDLE:
            begin
                take_single = can_take && !is_drain;
                start       = can_take && is_drain;
            end
            crc8fu_pkg::BK_DRAIN:
                issue = !rd_pend_reg && out_free;
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign pop             = take_single || start;
    assign rd_en           = issue;
    assign rd_addr         = {bank_reg, idx_reg};
    assign bank_free.valid = issue && final_read;
    assign bank_free.bank  = bank_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crc8fu_pkg::BK_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            if (rd_pend_reg || take_single)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame context and read tracking
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg  <= q_entry.command;
            len_reg  <= q_entry.length;
            bank_reg <= q_entry.bank;
            idx_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (issue)
        begin
            rd_idx_reg  <= idx_reg;
            rd_last_reg <= final_read;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            status_reg  <= crc8fu_pkg::STAT_FRAME;
            command_reg <= cmd_reg;
            length_reg  <= len_reg;
            pbyte_reg   <= rd_data;
            index_reg   <= rd_idx_reg;
            last_reg    <= rd_last_reg;
        end
        else if (take_single)
        begin
            status_reg  <= q_entry.status;
            command_reg <= q_entry.command;
            length_reg  <= q_entry.length;
            pbyte_reg   <= '0;
            index_reg   <= '0;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign command        = command_reg;
    assign payload_length = length_reg;
    assign payload_byte   = pbyte_reg;
    assign byte_index     = index_reg;
    assign last           = last_reg;

endmodule

>>> hw/rtl/crc8_framed_uart_receiver.sv
// ----------------------------------------------------------------------------
// crc8_framed_uart_receiver
// Frame parser for AA 55 / len / cmd / payload / CRC-8 / 0D 0A byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, byte_in) takes one received byte per
//   beat. Output channel (out_valid/out_ready) gives result beats: one per
//   payload byte of a good frame (last on the final one), one beat for an
//   empty payload, one status beat for a CRC mismatch or oversize length.
//   Bad header or tail bytes drop the frame without any beat.
//   The parser takes one byte per cycle while in_ready is high. Its events
//   pass through a two-entry queue to the drain engine, which reads the
//   payload RAM (two banks of 64 bytes) through its registered port and
//   issues each payload read only after the previous read has reached the
//   output register. in_ready drops while the queue is full, or while a
//   payload byte would land in a bank whose frame is not yet drained.
//   A stalled output only stalls the drain engine; the parser keeps taking
//   bytes until those limits are hit.
//   Reset (rst_n, asynchronous) returns the parser to hunting for AA and
//   empties the queue and output register; payload RAM needs no clearing.
// ----------------------------------------------------------------------------
module crc8_framed_uart_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] command,
    output logic [5:0] payload_length,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic       last
);

    logic                           push;
    crc8fu_pkg::frame_entry_t       push_entry;
    logic                           q_full;
    logic                           pop;
    logic                           q_valid;
    crc8fu_pkg::frame_entry_t       q_entry;
    crc8fu_pkg::bank_free_t         bank_free;
    logic                           wr_en;
    logic [crc8fu_pkg::RAM_AW-1:0]  wr_addr;
    logic [7:0]                     wr_data;
    logic                           rd_en;
    logic [crc8fu_pkg::RAM_AW-1:0]  rd_addr;
    logic [7:0]                     rd_data;

    // parser
    crc8fu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .bank_free  (bank_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // event queue
    crc8fu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // payload store, two banks
    crc8fu_ram #(
        .WIDTH (8),
        .DEPTH (crc8fu_pkg::RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // drain engine
    crc8fu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .pop            (pop),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .bank_free      (bank_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .command        (command),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

endmodule

>>> test/tb_crc8_framed_uart_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc8_framed_uart_receiver
// Self-checking bench for the CRC-8 framed serial receiver.
// A short directed set covers each frame outcome. A longer random run follows:
// mostly well-formed frames with random content, mixed with broken frames and
// line noise. Each accepted byte runs through a software copy of the parser.
// Each output beat is checked against the oldest predicted beat.
// Both handshake sides idle in random bursts; the tail of the run is unthrottled.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One predicted or observed output beat
typedef struct {
    logic [1:0] status;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
} result_beat_t;

// Software parser plus queue of beats still owed by the block
class frame_scoreboard;
    crc8fu_pkg::parse_state_t pstate;
    logic [7:0]   payload_mem [crc8fu_pkg::PAYLOAD_MAX];
    logic [5:0]   fill_pos;
    logic [7:0]   hdr_len;
    logic [7:0]   hdr_cmd;
    logic [7:0]   crc_acc;
    result_beat_t owed_beats[$];
    int           errors;

    function new();
        pstate   = crc8fu_pkg::PS_HEAD1;
        fill_pos = '0;
        hdr_len  = '0;
        hdr_cmd  = '0;
        crc_acc  = '0;
        errors   = 0;
    endfunction

    // Bit-serial CRC-8, MSB first
    static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        int         i;
        acc = crc;
        for (i = 7; i >= 0; i--)
        begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? crc8fu_pkg::CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    function void owe_beat(input logic [1:0] st, input logic [7:0] cmd,
                           input logic [5:0] len, input logic [7:0] pb,
                           input logic [5:0] idx, input logic lst);
        result_beat_t beat;
        beat.status         = st;
        beat.command        = cmd;
        beat.payload_length = len;
        beat.payload_byte   = pb;
        beat.byte_index     = idx;
        beat.last           = lst;
        owed_beats.push_back(beat);
    endfunction

    // Advance the parser by one accepted byte
    function void take_byte(input logic [7:0] b);
        int i;
        case (pstate)
            crc8fu_pkg::PS_HEAD1:
            begin
                if (b == crc8fu_pkg::HEAD1_BYTE)
                    pstate = crc8fu_pkg::PS_HEAD2;
            end
            crc8fu_pkg::PS_HEAD2:
            begin
                if (b == crc8fu_pkg::HEAD2_BYTE)
                    pstate = crc8fu_pkg::PS_LEN;
                else
                    pstate = crc8fu_pkg::PS_HEAD1;
            end
            crc8fu_pkg::PS_LEN:
            begin
                hdr_len = b;
                crc_acc = crc_step(8'h00, b);
                if (b <= crc8fu_pkg::PAYLOAD_MAX)
                begin
                    fill_pos = '0;
                    pstate   = crc8fu_pkg::PS_CMD;
                end
                else
                begin
                    owe_beat(crc8fu_pkg::STAT_LEN_ERR, 8'h00, 6'd0, 8'h00, 6'd0, 1'b1);
                    pstate = crc8fu_pkg::PS_HEAD1;
                end
            end
            crc8fu_pkg::PS_CMD:
            begin
                hdr_cmd = b;
                crc_acc = crc_step(crc_acc, b);
                if (hdr_len != 8'd0)
                    pstate = crc8fu_pkg::PS_DATA;
                else
                    pstate = crc8fu_pkg::PS_CRC;
            end
            crc8fu_pkg::PS_DATA:
            begin
                if (fill_pos < crc8fu_pkg::PAYLOAD_MAX)
                    payload_mem[fill_pos] = b;
                fill_pos = fill_pos + 6'd1;
                crc_acc  = crc_step(crc_acc, b);
                if ({2'b00, fill_pos} >= hdr_len)
                    pstate = crc8fu_pkg::PS_CRC;
            end
            crc8fu_pkg::PS_CRC:
            begin
                if (b == crc_acc)
                    pstate = crc8fu_pkg::PS_TAIL1;
                else
                begin
                    owe_beat(crc8fu_pkg::STAT_CRC_ERR, hdr_cmd, hdr_len[5:0],
                             8'h00, 6'd0, 1'b1);
                    pstate = crc8fu_pkg::PS_HEAD1;
                end
            end
            crc8fu_pkg::PS_TAIL1:
            begin
                if (b == crc8fu_pkg::TAIL1_BYTE)
                    pstate = crc8fu_pkg::PS_TAIL2;
                else
                    pstate = crc8fu_pkg::PS_HEAD1;
            end
            default:
            begin
                // closing byte releases the buffered payload
                if (b == crc8fu_pkg::TAIL2_BYTE)
                begin
                    if (hdr_len == 8'd0)
                        owe_beat(crc8fu_pkg::STAT_FRAME, hdr_cmd, 6'd0, 8'h00, 6'd0, 1'b1);
                    else
                        for (i = 0; i < hdr_len; i++)
                            owe_beat(crc8fu_pkg::STAT_FRAME, hdr_cmd, hdr_len[5:0],
                                     payload_mem[i], i[5:0], i == hdr_len - 1);
                end
                pstate = crc8fu_pkg::PS_HEAD1;
            end
        endcase
    endfunction

    function void compare_field(input string name, input logic [7:0] exp_val,
                                input logic [7:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endfunction

    // Match one observed beat against the oldest owed one
    function void check_beat(input result_beat_t got);
        result_beat_t want;
        if (owed_beats.size() == 0)
        begin
            $error("unexpected result beat: status %0d command %0d", got.status, got.command);
            errors++;
            return;
        end
        want = owed_beats.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("command", want.command, got.command);
        compare_field("payload_length", want.payload_length, got.payload_length);
        compare_field("payload_byte", want.payload_byte, got.payload_byte);
        compare_field("byte_index", want.byte_index, got.byte_index);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module tb_crc8_framed_uart_receiver;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 95;
    localparam int QUIET_AFTER  = 65;
    localparam int SETTLE       = 16;

    typedef enum {
        SEQ_GOOD,
        SEQ_FULL,
        SEQ_CRC_BAD,
        SEQ_LEN_BAD,
        SEQ_HEAD_BAD,
        SEQ_TAIL1_BAD,
        SEQ_TAIL2_BAD,
        SEQ_NOISE
    } seq_kind_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] byte_in   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;

    frame_scoreboard sb = new();
    logic [7:0]      payload_q[$];
    bit              idle_enable = 1'b1;
    int              bytes_sent  = 0;
    int              sink_hold   = 0;
    int unsigned     cycle_count = 0;

    crc8_framed_uart_receiver uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .command        (command),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    always #6 clk = ~clk;

    // Output side: random stall bursts
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= (sink_hold == 1);
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            sink_hold <= $urandom_range(1, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        result_beat_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.status         = status;
            seen.command        = command;
            seen.payload_length = payload_length;
            seen.payload_byte   = payload_byte;
            seen.byte_index     = byte_index;
            seen.last           = last;
            sb.check_beat(seen);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] rand_except(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == avoid)
            v = ~avoid;
        return v;
    endfunction

    // One input beat; valid stays high into the next call unless a gap is taken
    task automatic send_byte(input logic [7:0] b);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] len);
        send_byte(crc8fu_pkg::HEAD1_BYTE);
        send_byte(crc8fu_pkg::HEAD2_BYTE);
        send_byte(len);
    endtask

    task automatic fill_payload(input int n);
        payload_q.delete();
        repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Frame around payload_q; a nonzero crc_flip corrupts the CRC and skips the tail
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] crc_flip,
                              input logic [7:0] tail_a, input logic [7:0] tail_b);
        logic [7:0] len;
        logic [7:0] crc;
        len = 8'(payload_q.size());
        crc = sb.crc_step(sb.crc_step(8'h00, len), cmd);
        send_header(len);
        send_byte(cmd);
        foreach (payload_q[i])
        begin
            send_byte(payload_q[i]);
            crc = sb.crc_step(crc, payload_q[i]);
        end
        send_byte(crc ^ crc_flip);
        if (crc_flip == 8'h00)
        begin
            send_byte(tail_a);
            send_byte(tail_b);
        end
    endtask

    initial
    begin
        seq_kind_t kind;
        int        seq_count;
        int        rand_start;
        int        r;
        int        n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frame, oversize lengths, broken header, bad CRC, bad tail
        fill_payload(0);
        send_frame(8'h00, 8'h00, crc8fu_pkg::TAIL1_BYTE, crc8fu_pkg::TAIL2_BYTE);
        send_header(8'hFF);
        send_header(8'(crc8fu_pkg::PAYLOAD_MAX + 1));
        send_byte(crc8fu_pkg::HEAD1_BYTE);
        send_byte(crc8fu_pkg::HEAD1_BYTE);
        send_frame(8'hFF, 8'h5A, crc8fu_pkg::TAIL1_BYTE, crc8fu_pkg::TAIL2_BYTE);
        send_frame(8'h3C, 8'h00, crc8fu_pkg::TAIL1_BYTE, 8'h0B);

        // Random: mostly good frames, some broken ones and noise
        seq_count  = 0;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            if (bytes_sent - rand_start > QUIET_AFTER)
                idle_enable = 1'b0;
            r = $urandom_range(0, 19);
            if (seq_count == 0)
                kind = SEQ_FULL;
            else if (seq_count == 1)
                kind = SEQ_TAIL1_BAD;
            else if (r < 11)
                kind = SEQ_GOOD;
            else if (r < 13)
                kind = SEQ_CRC_BAD;
            else if (r < 14)
                kind = SEQ_LEN_BAD;
            else if (r < 15)
                kind = SEQ_HEAD_BAD;
            else if (r < 16)
                kind = SEQ_TAIL1_BAD;
            else if (r < 17)
                kind = SEQ_TAIL2_BAD;
            else if (r < 19)
                kind = SEQ_NOISE;
            else
                kind = SEQ_FULL;
            seq_count++;

            case (kind)
                SEQ_GOOD:
                begin
                    r = $urandom_range(0, 9);
                    n = (r < 9) ? $urandom_range(0, 8)
                                : $urandom_range(9, crc8fu_pkg::PAYLOAD_MAX - 1);
                    fill_payload(n);
                    send_frame(8'($urandom_range(0, 255)), 8'h00,
                               crc8fu_pkg::TAIL1_BYTE, crc8fu_pkg::TAIL2_BYTE);
                end
                SEQ_FULL:
                begin
                    fill_payload(crc8fu_pkg::PAYLOAD_MAX);
                    send_frame(8'($urandom_range(0, 255)), 8'h00,
                               crc8fu_pkg::TAIL1_BYTE, crc8fu_pkg::TAIL2_BYTE);
                end
                SEQ_CRC_BAD:
                begin
                    fill_payload($urandom_range(0, 6));
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                               crc8fu_pkg::TAIL1_BYTE, crc8fu_pkg::TAIL2_BYTE);
                end
                SEQ_LEN_BAD:
                    send_header(8'($urandom_range(crc8fu_pkg::PAYLOAD_MAX + 1, 255)));
                SEQ_HEAD_BAD:
                begin
                    send_byte(crc8fu_pkg::HEAD1_BYTE);
                    send_byte(rand_except(crc8fu_pkg::HEAD2_BYTE));
                end
                SEQ_TAIL1_BAD:
                begin
                    fill_payload($urandom_range(0, 6));
                    send_frame(8'($urandom_range(0, 255)), 8'h00,
                               rand_except(crc8fu_pkg::TAIL1_BYTE), crc8fu_pkg::TAIL2_BYTE);
                end
                SEQ_TAIL2_BAD:
                begin
                    fill_payload($urandom_range(0, 6));
                    send_frame(8'($urandom_range(0, 255)), 8'h00,
                               crc8fu_pkg::TAIL1_BYTE, rand_except(crc8fu_pkg::TAIL2_BYTE));
                end
                default:
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        in_valid <= 1'b0;

        // Drain outstanding beats, then let the block settle
        while (sb.owed_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
